### sv/dpi_pkg.sv
// ----------------------------------------------------------------------------
// dpi_pkg: shared definitions for the 64-bit immediate data-processing core
// Instruction field codes, register file geometry and opcode names.
// ----------------------------------------------------------------------------
package dpi_pkg;

   // register file geometry
   localparam int REG_COUNT = 31;
   localparam int IDX_W     = 5;
   localparam int DATA_W    = 64;
   localparam int WORD_W    = 32;
   localparam int FLAG_W    = 4;

   localparam logic [IDX_W-1:0]  ZERO_REG  = 5'd31;
   localparam logic [FLAG_W-1:0] NZCV_RESET = 4'b0100;

   // class patterns at bits 28..23
   localparam logic [5:0] CLASS_ADDSUB = 6'b100010;
   localparam logic [5:0] CLASS_WIDE   = 6'b100101;

   // opc codes, add/sub immediate
   localparam logic [1:0] OPC_ADD  = 2'b00;
   localparam logic [1:0] OPC_ADDS = 2'b01;
   localparam logic [1:0] OPC_SUB  = 2'b10;
   localparam logic [1:0] OPC_SUBS = 2'b11;

   // opc codes, wide move
   localparam logic [1:0] OPC_MOVN     = 2'b00;
   localparam logic [1:0] OPC_WIDE_BAD = 2'b01;
   localparam logic [1:0] OPC_MOVZ     = 2'b10;
   localparam logic [1:0] OPC_MOVK     = 2'b11;

   localparam logic [DATA_W-1:0] HALF_MASK = 64'h0000_0000_0000_FFFF;

endpackage

### sv/dpi_req_if.sv
// ----------------------------------------------------------------------------
// dpi_req_if: instruction channel
// Valid/ready channel carrying one 32-bit instruction word per item.
// ----------------------------------------------------------------------------
interface dpi_req_if
   import dpi_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] instruction_word;

   modport source (output valid, output instruction_word, input ready);
   modport sink   (input valid, input instruction_word, output ready);
endinterface

### sv/dpi_rsp_if.sv
// ----------------------------------------------------------------------------
// dpi_rsp_if: write-back report channel
// Valid/ready channel carrying one write-back report per item.
// ----------------------------------------------------------------------------
interface dpi_rsp_if
   import dpi_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [IDX_W-1:0]  dest_index;
   logic [DATA_W-1:0] write_value;
   logic [FLAG_W-1:0] flags_after;

   modport source (output valid, output accepted, output dest_index,
                   output write_value, output flags_after, input ready);
   modport sink   (input valid, input accepted, input dest_index,
                   input write_value, input flags_after, output ready);
endinterface

### sv/dp_immediate_execute_64_core.sv
// ----------------------------------------------------------------------------
// dp_immediate_execute_64_core: 64-bit A64 data-processing-immediate execute
// Executes ADD/ADDS/SUB/SUBS (immediate) and MOVN/MOVZ/MOVK against a
// 31-entry register file and the NZCV flags, one report per item.
// ----------------------------------------------------------------------------
// The core accepts one instruction item every cycle unless the report stalls:
// the register file is read at the accepting edge (one read port, Rn for
// add/sub, Rd for MOVK), the add or move is done in the execute stage and
// the report lands in the output register, while the register write and
// the flags commit at the same edge. A result written at the edge where the
// next item reads the same register is bypassed. When the report is not
// taken, the execute stage holds and input ready drops in the same cycle
// while an item waits there. Register contents come out of reset as zero
// through per-entry valid bits, so no clearing pass is needed and items are
// taken right after reset.
module dp_immediate_execute_64_core
   import dpi_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   dpi_req_if.sink   req,
   dpi_rsp_if.source rsp
);

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_adv;
   logic req_take;

   // execute stage payload
   logic [WORD_W-1:0] s1_word_ff;
   logic              src_ok_ff;
   logic              byp_hit_ff;
   logic [DATA_W-1:0] byp_val_ff;
   logic [DATA_W-1:0] rdata_ff;

   // register file and flags
   logic [DATA_W-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [FLAG_W-1:0] nzcv_ff, nzcv_in;

   // output register
   logic              out_acc_ff;
   logic [IDX_W-1:0]  out_dest_ff;
   logic [DATA_W-1:0] out_val_ff;
   logic [FLAG_W-1:0] out_flags_ff;

   // read address selection at the input
   logic [IDX_W-1:0] src_idx;
   logic             src_ok_in;
   logic             byp_hit_in;

   // execute stage decode and datapath
   logic              ex_sf;
   logic [1:0]        ex_opc;
   logic [5:0]        ex_cls;
   logic [IDX_W-1:0]  ex_rd;
   logic              ex_is_as;
   logic              ex_is_wide;
   logic              ex_ok;
   logic [DATA_W-1:0] ex_a;
   logic [DATA_W-1:0] ex_imm;
   logic [DATA_W-1:0] ex_b;
   logic [DATA_W:0]   ex_sum;
   logic [5:0]        ex_sa;
   logic [DATA_W-1:0] ex_placed;
   logic [DATA_W-1:0] ex_mask;
   logic [DATA_W-1:0] ex_res;
   logic              ex_c;
   logic              ex_v;
   logic              ex_wr_en;

   // handshake
   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_take = req.valid && req.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_adv ? 1'b1 : ((rsp.ready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // source register: Rd for a wide move (MOVK), Rn otherwise
   always_comb begin
      if (req.instruction_word[28:23] == CLASS_WIDE) begin
         src_idx = req.instruction_word[4:0];
      end else begin
         src_idx = req.instruction_word[9:5];
      end
      src_ok_in  = (src_idx != ZERO_REG) && vld_ff[src_idx];
      byp_hit_in = ex_wr_en && (ex_rd == src_idx);
   end

   // input register and bypass capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req.instruction_word;
         src_ok_ff  <= src_ok_in;
         byp_hit_ff <= byp_hit_in;
         byp_val_ff <= ex_res;
      end
   end

   // register file: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ex_wr_en) begin
         mem[ex_rd] <= ex_res;
      end
      if (req_take) begin
         rdata_ff <= mem[src_idx];
      end
   end

   // valid bits stand for the all-zero reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ex_wr_en) begin
         vld_ff[ex_rd] <= 1'b1;
      end
   end

   // decode of the item in the execute stage
   always_comb begin
      ex_sf      = s1_word_ff[31];
      ex_opc     = s1_word_ff[30:29];
      ex_cls     = s1_word_ff[28:23];
      ex_rd      = s1_word_ff[4:0];
      ex_is_as   = ex_sf && (ex_cls == CLASS_ADDSUB);
      ex_is_wide = ex_sf && (ex_cls == CLASS_WIDE) && (ex_opc != OPC_WIDE_BAD);
      ex_ok      = ex_is_as || ex_is_wide;
   end

   // source operand with write-back bypass
   always_comb begin
      if (byp_hit_ff) begin
         ex_a = byp_val_ff;
      end else if (src_ok_ff) begin
         ex_a = rdata_ff;
      end else begin
         ex_a = '0;
      end
   end

   // add/sub datapath, subtract as add of the inverted immediate plus one
   always_comb begin
      if (s1_word_ff[22]) begin
         ex_imm = {40'd0, s1_word_ff[21:10], 12'd0};
      end else begin
         ex_imm = {52'd0, s1_word_ff[21:10]};
      end
      ex_b   = ex_opc[1] ? ~ex_imm : ex_imm;
      ex_sum = {1'b0, ex_a} + {1'b0, ex_b} + {{DATA_W{1'b0}}, ex_opc[1]};
      ex_c   = ex_sum[DATA_W];
      ex_v   = (ex_a[DATA_W-1] == ex_b[DATA_W-1]) &&
               (ex_sum[DATA_W-1] != ex_a[DATA_W-1]);
   end

   // wide move datapath
   always_comb begin
      ex_sa     = {s1_word_ff[22:21], 4'd0};
      ex_placed = {48'd0, s1_word_ff[20:5]} << ex_sa;
      ex_mask   = HALF_MASK << ex_sa;
   end

   // result selection
   always_comb begin
      ex_res = '0;
      if (ex_is_as) begin
         ex_res = ex_sum[DATA_W-1:0];
      end else if (ex_is_wide) begin
         unique case (ex_opc)
            OPC_MOVN: ex_res = ~ex_placed;
            OPC_MOVZ: ex_res = ex_placed;
            OPC_MOVK: ex_res = (ex_a & ~ex_mask) | ex_placed;
            default:  ex_res = ex_placed;
         endcase
      end
   end

   // write enable and flag update; writes to register 31 are dropped
   always_comb begin
      ex_wr_en = s1_adv && ex_ok && (ex_rd != ZERO_REG);
      nzcv_in  = nzcv_ff;
      if (ex_is_as && ((ex_opc == OPC_ADDS) || (ex_opc == OPC_SUBS))) begin
         nzcv_in = {ex_res[DATA_W-1], (ex_res == '0), ex_c, ex_v};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nzcv_ff <= NZCV_RESET;
      end else if (s1_adv) begin
         nzcv_ff <= nzcv_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_acc_ff   <= ex_ok;
         out_dest_ff  <= ex_ok ? ex_rd : '0;
         out_val_ff   <= ex_ok ? ex_res : '0;
         out_flags_ff <= nzcv_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.accepted    = out_acc_ff;
   assign rsp.dest_index  = out_dest_ff;
   assign rsp.write_value = out_val_ff;
   assign rsp.flags_after = out_flags_ff;

   // a rejected item reports no destination and no value
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_acc_ff) |-> (out_dest_ff == '0 && out_val_ff == '0))
      else $error("rejected item reports a destination or value");

   // input ready drops only with both stages full and the report stalled
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && out_valid_ff && !rsp.ready))
      else $error("input not ready without a full stalled pipeline");

   // a stalled execute stage keeps its instruction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_word_ff)))
      else $error("execute stage lost its item while stalled");

   // flags move only when an item leaves the execute stage
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(nzcv_ff))
      else $error("flags changed without an executed item");

   // the register file is written only for an executed instruction
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      ex_wr_en |-> (s1_valid_ff && ex_ok && ex_rd != ZERO_REG))
      else $error("register write without an executed instruction");

endmodule

### bench/dp_immediate_execute_64_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dp_immediate_execute_64_core_test: testbench for the 64-bit immediate core
// Sends A64 data-processing-immediate words through the instruction channel.
// Each write-back report is checked against an in-bench architectural model
// of the register file and NZCV. A short table of hand-picked words comes
// first, then mostly well-formed random words. The sender runs in bursts and
// the receiver stalls, including one long hold-off that backs up the core.
// ----------------------------------------------------------------------------
module dp_immediate_execute_64_core_test;
   import dpi_pkg::*;

   typedef struct packed {
      logic              accepted;
      logic [IDX_W-1:0]  dest_index;
      logic [DATA_W-1:0] write_value;
      logic [FLAG_W-1:0] flags_after;
   } report_type;

   typedef struct {
      logic [WORD_W-1:0] word;
      bit                has_want;
      report_type        want;
   } dir_row_type;

   // a class pattern that belongs to neither supported group
   localparam logic [5:0] CLASS_UNUSED = 6'b000000;
   localparam int RANDOM_WORDS  = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 300;
   localparam int DRAIN_CYCLES  = 10;

   logic clock;
   logic reset;

   dpi_req_if req_bus ();
   dpi_rsp_if rsp_bus ();

   dp_immediate_execute_64_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // architectural state as the bench sees it
   logic [DATA_W-1:0] arch_regs [REG_COUNT];
   logic [FLAG_W-1:0] arch_flags;

   report_type expected_writebacks [$];
   int         mismatch_count;
   int         writebacks_seen;
   int         burst_left;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // reset
   initial begin
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("dp_immediate_execute_64_core test failed");
      $finish;
   end

   function automatic logic [WORD_W-1:0] enc_addsub(input logic sf, input logic [1:0] opc,
                                                     input logic sh, input logic [11:0] imm12,
                                                     input logic [IDX_W-1:0] rn,
                                                     input logic [IDX_W-1:0] rd);
      return {sf, opc, CLASS_ADDSUB, sh, imm12, rn, rd};
   endfunction

   function automatic logic [WORD_W-1:0] enc_wide(input logic sf, input logic [1:0] opc,
                                                   input logic [1:0] hw, input logic [15:0] imm16,
                                                   input logic [IDX_W-1:0] rd);
      return {sf, opc, CLASS_WIDE, hw, imm16, rd};
   endfunction

   function automatic logic [DATA_W-1:0] read_arch(input logic [IDX_W-1:0] idx);
      return (idx == ZERO_REG) ? '0 : arch_regs[idx];
   endfunction

   function automatic logic [FLAG_W-1:0] nzcv_of(input logic [DATA_W-1:0] res,
                                                 input logic carry, input logic ovf);
      return {res[DATA_W-1], res == '0, carry, ovf};
   endfunction

   // execute one word on the architectural state, return its report
   function automatic report_type execute_word(input logic [WORD_W-1:0] word);
      report_type        r;
      logic [1:0]        opc;
      logic [5:0]        cls;
      logic [IDX_W-1:0]  rd;
      logic [IDX_W-1:0]  rn;
      logic [DATA_W-1:0] src;
      logic [DATA_W-1:0] imm;
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] placed;
      logic [DATA_W-1:0] mask;
      opc = word[30:29];
      cls = word[28:23];
      rd  = word[4:0];
      rn  = word[9:5];
      r   = '0;
      if (word[31] && cls == CLASS_ADDSUB) begin
         imm = word[22] ? {40'b0, word[21:10], 12'b0} : {52'b0, word[21:10]};
         src = read_arch(rn);
         res = (opc == OPC_ADD || opc == OPC_ADDS) ? src + imm : src - imm;
         // flags always come from the source read before the write
         if (opc == OPC_ADDS)
            arch_flags = nzcv_of(res, res < src,
                                 ~(src[DATA_W-1] ^ imm[DATA_W-1]) &
                                 (src[DATA_W-1] ^ res[DATA_W-1]));
         else if (opc == OPC_SUBS)
            arch_flags = nzcv_of(res, src >= imm,
                                 (src[DATA_W-1] ^ imm[DATA_W-1]) &
                                 (src[DATA_W-1] ^ res[DATA_W-1]));
         if (rd != ZERO_REG)
            arch_regs[rd] = res;
         r.accepted    = 1'b1;
         r.dest_index  = rd;
         r.write_value = res;
      end else if (word[31] && cls == CLASS_WIDE && opc != OPC_WIDE_BAD) begin
         placed = {48'b0, word[20:5]} << (16 * word[22:21]);
         mask   = HALF_MASK << (16 * word[22:21]);
         case (opc)
            OPC_MOVN: res = ~placed;
            OPC_MOVZ: res = placed;
            default:  res = (read_arch(rd) & ~mask) | placed;
         endcase
         if (rd != ZERO_REG)
            arch_regs[rd] = res;
         r.accepted    = 1'b1;
         r.dest_index  = rd;
         r.write_value = res;
      end
      r.flags_after = arch_flags;
      return r;
   endfunction

   function automatic report_type rpt(input logic acc, input logic [IDX_W-1:0] dest,
                                      input logic [DATA_W-1:0] value,
                                      input logic [FLAG_W-1:0] flags);
      report_type r;
      r.accepted    = acc;
      r.dest_index  = dest;
      r.write_value = value;
      r.flags_after = flags;
      return r;
   endfunction

   // registers biased toward a few so that results feed later items
   function automatic logic [IDX_W-1:0] pick_reg();
      case ($urandom_range(0, 9))
         0, 1:    return 5'd0;
         2:       return 5'd1;
         3:       return 5'd2;
         4:       return 5'd30;
         5:       return ZERO_REG;
         default: return IDX_W'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_imm16();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      int         pick;
      logic [1:0] opc;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         return enc_addsub(1'b1, 2'($urandom), 1'($urandom), 12'(pick_imm16()),
                           pick_reg(), pick_reg());
      end else if (pick < 75) begin
         case ($urandom_range(0, 2))
            0:       opc = OPC_MOVN;
            1:       opc = OPC_MOVZ;
            default: opc = OPC_MOVK;
         endcase
         return enc_wide(1'b1, opc, 2'($urandom), pick_imm16(), pick_reg());
      end else if (pick < 82) begin
         return enc_wide(1'b1, OPC_WIDE_BAD, 2'($urandom), pick_imm16(), pick_reg());
      end else if (pick < 90) begin
         // 32-bit forms are rejected
         if ($urandom_range(0, 1))
            return enc_addsub(1'b0, 2'($urandom), 1'($urandom), 12'($urandom),
                              pick_reg(), pick_reg());
         return enc_wide(1'b0, 2'($urandom), 2'($urandom), pick_imm16(), pick_reg());
      end
      return $urandom;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // offer one item, predict at acceptance, then maybe open a gap
   task automatic send_word(input logic [WORD_W-1:0] word, input bit has_want,
                            input report_type want);
      report_type predicted;
      int         gap;
      req_bus.valid            <= 1'b1;
      req_bus.instruction_word <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = execute_word(word);
      expected_writebacks.push_back(has_want ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   // result side: check every accepted report against the oldest expectation
   always @(posedge clock) begin : check_writeback
      report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         writebacks_seen++;
         if (expected_writebacks.size() == 0) begin
            report_mismatch("unexpected report", rsp_bus.write_value, '0);
         end else begin
            want = expected_writebacks.pop_front();
            if (rsp_bus.accepted !== want.accepted)
               report_mismatch("accepted", DATA_W'(rsp_bus.accepted),
                               DATA_W'(want.accepted));
            if (rsp_bus.dest_index !== want.dest_index)
               report_mismatch("dest_index", DATA_W'(rsp_bus.dest_index),
                               DATA_W'(want.dest_index));
            if (rsp_bus.write_value !== want.write_value)
               report_mismatch("write_value", rsp_bus.write_value, want.write_value);
            if (rsp_bus.flags_after !== want.flags_after)
               report_mismatch("flags_after", DATA_W'(rsp_bus.flags_after),
                               DATA_W'(want.flags_after));
         end
      end
   end

   // result side: ready pattern with one long hold-off
   initial begin : rsp_stall
      int         seg;
      int         mode;
      int         phase;
      bit         held;
      logic [7:0] ready_pattern;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && writebacks_seen >= HOLD_AFTER) begin
            // long hold so the core fills up and drops input ready
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode          = $urandom_range(0, 2);
         seg           = $urandom_range(8, 64);
         ready_pattern = $urandom;
         phase         = 0;
         repeat (seg) begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom);
               default: rsp_bus.ready <= ready_pattern[phase % 8];
            endcase
            phase++;
            @(posedge clock);
         end
      end
   end

   // stimulus: directed table, then random words, then drain
   initial begin : stimulus
      dir_row_type dir_table [$];
      mismatch_count  = 0;
      writebacks_seen = 0;
      burst_left      = 0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_flags = NZCV_RESET;
      req_bus.valid            <= 1'b0;
      req_bus.instruction_word <= '0;

      // rejected 32-bit form right after reset
      dir_table.push_back('{enc_addsub(1'b0, OPC_ADD, 1'b0, 12'h123, 5'd1, 5'd2), 1'b1,
                            rpt(1'b0, '0, '0, 4'b0100)});
      // shifted immediate from the zero register
      dir_table.push_back('{enc_addsub(1'b1, OPC_ADD, 1'b1, 12'hFFF, ZERO_REG, 5'd1), 1'b1,
                            rpt(1'b1, 5'd1, 64'h0000_0000_00FF_F000, 4'b0100)});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVZ, 2'd3, 16'h8000, 5'd0), 1'b1,
                            rpt(1'b1, 5'd0, 64'h8000_0000_0000_0000, 4'b0100)});
      // subs with rd equal to rn, signed overflow
      dir_table.push_back('{enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'h001, 5'd0, 5'd0), 1'b1,
                            rpt(1'b1, 5'd0, 64'h7FFF_FFFF_FFFF_FFFF, 4'b0011)});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd1), 1'b1,
                            rpt(1'b1, 5'd1, 64'h7FFF_FFFF_FFFF_FFFF, 4'b0011)});
      // adds overflow into the sign bit
      dir_table.push_back('{enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'h001, 5'd1, 5'd2), 1'b1,
                            rpt(1'b1, 5'd2, 64'h8000_0000_0000_0000, 4'b1001)});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd3), 1'b1,
                            rpt(1'b1, 5'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'b1001)});
      // adds carry out to zero
      dir_table.push_back('{enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'h001, 5'd3, 5'd4), 1'b1,
                            rpt(1'b1, 5'd4, 64'h0, 4'b0110)});
      // compare zero with zero, destination discarded
      dir_table.push_back('{enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'h000, ZERO_REG, ZERO_REG), 1'b1,
                            rpt(1'b1, ZERO_REG, 64'h0, 4'b0110)});
      // non-flag form keeps nzcv
      dir_table.push_back('{enc_addsub(1'b1, OPC_SUB, 1'b0, 12'h001, ZERO_REG, 5'd5), 1'b1,
                            rpt(1'b1, 5'd5, 64'hFFFF_FFFF_FFFF_FFFF, 4'b0110)});
      dir_table.push_back('{enc_addsub(1'b1, OPC_SUBS, 1'b1, 12'hFFF, ZERO_REG, 5'd6), 1'b1,
                            rpt(1'b1, 5'd6, 64'hFFFF_FFFF_FF00_1000, 4'b1000)});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVK, 2'd2, 16'h1234, 5'd3), 1'b1,
                            rpt(1'b1, 5'd3, 64'hFFFF_1234_FFFF_FFFF, 4'b1000)});
      // movk on the zero register merges into zero
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVK, 2'd1, 16'hABCD, ZERO_REG), 1'b1,
                            rpt(1'b1, ZERO_REG, 64'h0000_0000_ABCD_0000, 4'b1000)});
      dir_table.push_back('{enc_wide(1'b1, OPC_WIDE_BAD, 2'd1, 16'hFFFF, 5'd7), 1'b1,
                            rpt(1'b0, '0, '0, 4'b1000)});
      dir_table.push_back('{{1'b1, OPC_ADD, CLASS_UNUSED, 23'h7F_FFFF}, 1'b1,
                            rpt(1'b0, '0, '0, 4'b1000)});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVZ, 2'd0, 16'hFFFF, 5'd30), 1'b1,
                            rpt(1'b1, 5'd30, 64'h0000_0000_0000_FFFF, 4'b1000)});
      // back-to-back dependent rows, left to the model
      dir_table.push_back('{enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'hFFF, 5'd30, 5'd30), 1'b0, '0});
      dir_table.push_back('{enc_addsub(1'b1, OPC_ADDS, 1'b1, 12'hFFF, 5'd3, 5'd7), 1'b0, '0});
      dir_table.push_back('{enc_addsub(1'b1, OPC_SUB, 1'b1, 12'h800, 5'd30, 5'd30), 1'b0, '0});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVK, 2'd3, 16'h0000, 5'd30), 1'b0, '0});
      dir_table.push_back('{enc_wide(1'b1, OPC_MOVN, 2'd3, 16'hFFFF, ZERO_REG), 1'b0, '0});
      dir_table.push_back('{enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'hFFF, 5'd30, 5'd8), 1'b0, '0});
      dir_table.push_back('{enc_addsub(1'b1, OPC_ADD, 1'b0, 12'h000, 5'd2, 5'd8), 1'b0, '0});
      dir_table.push_back('{32'hFFFF_FFFF, 1'b0, '0});
      dir_table.push_back('{32'h0000_0000, 1'b0, '0});

      do @(posedge clock); while (reset);

      foreach (dir_table[i])
         send_word(dir_table[i].word, dir_table[i].has_want, dir_table[i].want);
      repeat (RANDOM_WORDS)
         send_word(random_word(), 1'b0, '0);
      req_bus.valid <= 1'b0;

      // drain, then let any stray report show up
      while (expected_writebacks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_writebacks.size() == 0)
         $display("dp_immediate_execute_64_core test passed");
      else
         $display("dp_immediate_execute_64_core test failed");
      $finish;
   end

endmodule
